// ===== hw/rtl/gmlf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmlf_pkg: shared types and constants of the grid localization filter
// Transaction layouts, operation and status codes, configuration indexes,
// sequencer states and the neighbour direction table.
// ----------------------------------------------------------------------------
package gmlf_pkg;

	typedef enum logic [1:0] {
		FUNC_LOAD  = 2'd0,
		FUNC_START = 2'd1,
		FUNC_STEP  = 2'd2,
		FUNC_READ  = 2'd3
	} func_e;

	typedef enum logic [1:0] {
		STATUS_OK          = 2'd0,
		STATUS_NOT_STARTED = 2'd1,
		STATUS_ALL_ZERO    = 2'd2
	} status_e;

	localparam logic [1:0] CFG_SENSOR_ERROR = 2'd0;
	localparam logic [1:0] CFG_GRID_ROWS    = 2'd1;
	localparam logic [1:0] CFG_GRID_COLS    = 2'd2;

	localparam logic [7:0]  ALL_BLOCKED = 8'hFF;
	localparam logic [16:0] Q16_ONE     = 17'h10000;
	localparam logic [33:0] Q16_HALF    = 34'd32768;

	// E, NE, N, NW, W, SW, S, SE; north is row - 1, east is col + 1
	localparam logic signed [1:0] DIR_DX [8] =
		'{2'sd1, 2'sd1, 2'sd0, -2'sd1, -2'sd1, -2'sd1, 2'sd0, 2'sd1};
	localparam logic signed [1:0] DIR_DY [8] =
		'{2'sd0, -2'sd1, -2'sd1, -2'sd1, 2'sd0, 2'sd1, 2'sd1, 2'sd1};

	typedef enum logic [4:0] {
		S_IDLE,
		S_RD_WAIT,
		S_W_MUL,
		S_W_UPD,
		S_M_OWN,
		S_M_CHK,
		S_M_NB,
		S_M_NBD,
		S_M_WR,
		S_P_OWN,
		S_P_CHK,
		S_P_NB,
		S_P_DIV,
		S_P_WMUL,
		S_P_WR,
		S_N_INIT,
		S_N_MSB,
		S_N_RD,
		S_N_WR,
		S_DONE
	} state_e;

	typedef struct packed {
		logic [1:0] func;
		logic [3:0] cell_row;
		logic [3:0] cell_col;
		logic       cell_wall;
		logic [7:0] sensed_mask;
	} in_item_t;

	typedef struct packed {
		logic [15:0] belief;
		logic [3:0]  peak_row;
		logic [3:0]  peak_col;
		logic [1:0]  status;
	} out_item_t;

	function automatic logic [3:0] ones8(input logic [7:0] v);
		return 4'($countones(v));
	endfunction

endpackage

// ===== hw/rtl/grid_markov_localization_filter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_markov_localization_filter_top: grid Markov localization filter
// Loads an occupancy grid, starts the filter and runs observation steps.
// ----------------------------------------------------------------------------
// Usage: map cells are loaded with load transactions, then a start
// transaction builds the neighbour masks, the sensor weight table and an even
// belief. Each step transaction spreads belief to open neighbours, weighs it by
// the sensed mask and rescales so the peak fills the top belief bit. Read
// transactions return one cell's belief. Every transaction gives one result
// with the current peak cell and a status code.
// A load or not-started result goes straight to the done state; a read first
// waits on the belief memory. Start builds the weight table on the shared
// multiplier, then walks each active cell: a wall cell gets an all-blocked
// mask, an open cell checks each in-grid neighbour for a wall; the rescale
// pass follows. Step walks each active cell: cells with an all-blocked mask
// are skipped, open cells sum a share of each open neighbour's belief and
// weigh the sum; the rescale pass follows. The rescale pass finds the peak's
// top bit, then rewrites each active belief. One memory read port each and
// the shared multiplier set the rate; one transaction is in work at a time.
// Reset clears configuration to its defaults, the started flag and the peak.
// A stalled receiver holds the result register; one more transaction is
// accepted and its result waits until the register frees.
// ----------------------------------------------------------------------------
module grid_markov_localization_filter_top
	import gmlf_pkg::*;
#(
	parameter int MAX_ROWS    = 16,
	parameter int MAX_COLS    = 16,
	parameter int BELIEF_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data,
	input  logic      cfg_we,
	input  logic [1:0] cfg_addr,
	input  logic [15:0] cfg_wdata
);

	localparam int AW     = $clog2(MAX_ROWS * MAX_COLS);
	localparam int RIW    = $clog2(MAX_ROWS);
	localparam int CIW    = $clog2(MAX_COLS);
	localparam int RCW    = $clog2(MAX_ROWS + 1);
	localparam int CCW    = $clog2(MAX_COLS + 1);
	localparam int XW     = BELIEF_BITS + 8;
	localparam int SW     = BELIEF_BITS + 11;
	localparam int RWW    = BELIEF_BITS + 27;
	localparam int MA     = BELIEF_BITS + 12;
	localparam int MB     = BELIEF_BITS + 11;
	localparam int PW     = MA + MB;
	localparam int DIV_SH = XW + 3;
	localparam int SHW    = $clog2(RWW);
	localparam logic [63:0] ONE_S = 64'd1 << DIV_SH;
	localparam logic [MA-1:0] RECIP [8] = '{
		MA'(ONE_S),
		MA'((ONE_S + 64'd1) / 64'd2),
		MA'((ONE_S + 64'd2) / 64'd3),
		MA'((ONE_S + 64'd3) / 64'd4),
		MA'((ONE_S + 64'd4) / 64'd5),
		MA'((ONE_S + 64'd5) / 64'd6),
		MA'((ONE_S + 64'd6) / 64'd7),
		MA'((ONE_S + 64'd7) / 64'd8)
	};

	state_e state_q, state_d;

	logic [15:0]   sensor_error_q;
	logic [4:0]    grid_rows_q;
	logic [4:0]    grid_cols_q;
	logic          started_q;
	in_item_t      item_q;
	logic [RIW-1:0] r_q;
	logic [CIW-1:0] c_q;
	logic [3:0]    k_q;
	logic [3:0]    d_q;
	logic [16:0]   w_q;
	logic [15:0]   weight_q [9];
	logic [7:0]    m_q;
	logic [SW-1:0] sum_q;
	logic          pend_q;
	logic [RWW-1:0] best_q;
	logic [RIW-1:0] peak_r_q;
	logic [CIW-1:0] peak_c_q;
	logic [RWW-1:0] tmp_q;
	logic [SHW-1:0] sh_q;
	logic [15:0]   res_belief_q;
	logic [1:0]    res_status_q;
	logic          out_valid_q;
	out_item_t     out_q;

	logic           in_acc;
	logic [RCW-1:0] act_rows;
	logic [CCW-1:0] act_cols;
	logic [AW-1:0]  own_idx, in_idx, nb_idx;
	logic signed [RIW+1:0] nr;
	logic signed [CIW+1:0] nc;
	logic           nb_in;
	logic           last_col, last_cell;
	logic           msb_done;
	logic           load_ok;

	logic          wall_we, wall_wdata, wall_rd;
	logic [AW-1:0] wall_waddr, wall_raddr;
	logic          mask_we;
	logic [7:0]    mask_wdata, mask_rd;
	logic [AW-1:0] mask_waddr, mask_raddr;
	logic          bel_we;
	logic [BELIEF_BITS-1:0] bel_wdata, bel_rd;
	logic [AW-1:0] bel_waddr, bel_raddr;
	logic          raw_we;
	logic [RWW-1:0] raw_wdata, raw_rd;
	logic [AW-1:0] raw_waddr, raw_raddr;

	logic [MA-1:0] mul_a;
	logic [MB-1:0] mul_b;
	logic [PW-1:0] prod;
	logic [XW-1:0] quot;
	logic [16:0]   w_new;
	logic [16:0]   factor;
	logic [3:0]    cnt;
	logic [3:0]    wi;
	logic [RWW-1:0] shifted;
	logic [BELIEF_BITS+15:0] read_ext;

	assign in_acc   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		if (grid_rows_q == 5'd0) begin
			act_rows = RCW'(1);
		end else if (int'(grid_rows_q) > MAX_ROWS) begin
			act_rows = RCW'(MAX_ROWS);
		end else begin
			act_rows = RCW'(grid_rows_q);
		end
		if (grid_cols_q == 5'd0) begin
			act_cols = CCW'(1);
		end else if (int'(grid_cols_q) > MAX_COLS) begin
			act_cols = CCW'(MAX_COLS);
		end else begin
			act_cols = CCW'(grid_cols_q);
		end
	end

	assign own_idx = AW'(int'(r_q) * MAX_COLS + int'(c_q));
	assign in_idx  = AW'(int'(in_data.cell_row) * MAX_COLS + int'(in_data.cell_col));
	assign load_ok = (int'(in_data.cell_row) < MAX_ROWS) && (int'(in_data.cell_col) < MAX_COLS);

	assign nr = $signed({2'b00, r_q}) + (RIW+2)'(DIR_DY[k_q[2:0]]);
	assign nc = $signed({2'b00, c_q}) + (CIW+2)'(DIR_DX[k_q[2:0]]);
	assign nb_in = !nr[RIW+1] && (nr[RIW:0] < (RIW+1)'(act_rows)) &&
		!nc[CIW+1] && (nc[CIW:0] < (CIW+1)'(act_cols));
	assign nb_idx = AW'(int'(nr[RIW-1:0]) * MAX_COLS + int'(nc[CIW-1:0]));

	assign last_col  = (CCW'(c_q) == act_cols - CCW'(1));
	assign last_cell = last_col && (RCW'(r_q) == act_rows - RCW'(1));
	assign msb_done  = tmp_q[RWW-1] || (sh_q == SHW'(RWW - 1));

	assign quot   = prod[DIV_SH +: XW];
	assign w_new  = 17'((prod[33:0] + Q16_HALF) >> 16);
	assign factor = (k_q < d_q) ? {1'b0, sensor_error_q} : Q16_ONE - {1'b0, sensor_error_q};
	assign cnt    = 4'd8 - ones8(mask_rd);
	assign wi     = ones8(m_q ^ item_q.sensed_mask);
	assign shifted  = raw_rd << sh_q;
	assign read_ext = {bel_rd, 16'h0000};

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					unique case (in_data.func)
						FUNC_LOAD:  state_d = S_DONE;
						FUNC_START: state_d = S_W_MUL;
						FUNC_STEP:  state_d = started_q ? S_P_OWN : S_DONE;
						FUNC_READ:  state_d = started_q ? S_RD_WAIT : S_DONE;
						default:    state_d = S_DONE;
					endcase
				end
			end
			S_RD_WAIT: state_d = S_DONE;
			S_W_MUL:   state_d = S_W_UPD;
			S_W_UPD:   state_d = (k_q == 4'd7 && d_q == 4'd8) ? S_M_OWN : S_W_MUL;
			S_M_OWN:   state_d = S_M_CHK;
			S_M_CHK: begin
				if (wall_rd) begin
					state_d = last_cell ? S_N_INIT : S_M_OWN;
				end else begin
					state_d = S_M_NB;
				end
			end
			S_M_NB: begin
				priority if (k_q == 4'd8) begin
					state_d = S_M_WR;
				end else if (nb_in) begin
					state_d = S_M_NBD;
				end
			end
			S_M_NBD:   state_d = S_M_NB;
			S_M_WR:    state_d = last_cell ? S_N_INIT : S_M_OWN;
			S_P_OWN:   state_d = S_P_CHK;
			S_P_CHK: begin
				if (mask_rd == ALL_BLOCKED) begin
					state_d = last_cell ? S_N_INIT : S_P_OWN;
				end else begin
					state_d = S_P_NB;
				end
			end
			S_P_NB: begin
				priority if (k_q == 4'd8) begin
					state_d = S_P_WMUL;
				end else if (!m_q[k_q[2:0]] && nb_in) begin
					state_d = S_P_DIV;
				end
			end
			S_P_DIV:   state_d = S_P_NB;
			S_P_WMUL:  state_d = S_P_WR;
			S_P_WR:    state_d = last_cell ? S_N_INIT : S_P_OWN;
			S_N_INIT:  state_d = S_N_MSB;
			S_N_MSB:   state_d = msb_done ? S_N_RD : S_N_MSB;
			S_N_RD:    state_d = S_N_WR;
			S_N_WR:    state_d = last_cell ? S_DONE : S_N_RD;
			S_DONE:    state_d = out_valid_q ? S_DONE : S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	// memory and multiplier controls
	always_comb begin
		wall_we    = 1'b0;
		wall_waddr = in_idx;
		wall_wdata = in_data.cell_wall;
		wall_raddr = own_idx;
		mask_we    = 1'b0;
		mask_waddr = own_idx;
		mask_wdata = m_q;
		mask_raddr = own_idx;
		bel_we     = 1'b0;
		bel_waddr  = own_idx;
		bel_wdata  = shifted[RWW-1 -: BELIEF_BITS];
		bel_raddr  = own_idx;
		raw_we     = 1'b0;
		raw_waddr  = own_idx;
		raw_wdata  = '0;
		raw_raddr  = own_idx;
		mul_a      = '0;
		mul_b      = '0;
		unique case (state_q)
			S_IDLE: begin
				wall_we   = in_acc && (in_data.func == FUNC_LOAD) && load_ok;
				bel_raddr = in_idx;
			end
			S_W_MUL: begin
				mul_a = MA'(factor);
				mul_b = MB'(w_q);
			end
			S_M_CHK: begin
				if (wall_rd) begin
					mask_we    = 1'b1;
					mask_wdata = ALL_BLOCKED;
					raw_we     = 1'b1;
				end
			end
			S_M_NB: wall_raddr = nb_idx;
			S_M_WR: begin
				mask_we   = 1'b1;
				raw_we    = 1'b1;
				raw_wdata = RWW'(1) << (BELIEF_BITS - 1);
			end
			S_P_CHK: raw_we = (mask_rd == ALL_BLOCKED);
			S_P_NB: begin
				mask_raddr = nb_idx;
				bel_raddr  = nb_idx;
			end
			S_P_DIV: begin
				mul_a = RECIP[3'(cnt - 4'd1)];
				mul_b = MB'({bel_rd, 8'h00});
			end
			S_P_WMUL: begin
				mul_a = MA'(weight_q[wi]);
				mul_b = sum_q;
			end
			S_P_WR: begin
				raw_we    = 1'b1;
				raw_wdata = prod[RWW-1:0];
			end
			S_N_WR: bel_we = 1'b1;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			sensor_error_q <= 16'd3277;
			grid_rows_q    <= 5'd16;
			grid_cols_q    <= 5'd16;
			started_q      <= 1'b0;
			peak_r_q       <= '0;
			peak_c_q       <= '0;
			out_valid_q    <= 1'b0;
			k_q            <= '0;
			d_q            <= '0;
			pend_q         <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_we) begin
				unique case (cfg_addr)
					CFG_SENSOR_ERROR: sensor_error_q <= cfg_wdata;
					CFG_GRID_ROWS: begin
						grid_rows_q <= cfg_wdata[4:0];
						started_q   <= 1'b0;
					end
					CFG_GRID_COLS: begin
						grid_cols_q <= cfg_wdata[4:0];
						started_q   <= 1'b0;
					end
					default: begin
					end
				endcase
			end

			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (raw_we && (raw_wdata > best_q)) begin
				best_q   <= raw_wdata;
				peak_r_q <= r_q;
				peak_c_q <= c_q;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						item_q       <= in_data;
						res_belief_q <= '0;
						res_status_q <= STATUS_OK;
						if (in_data.func == FUNC_START) begin
							started_q <= 1'b1;
							w_q       <= Q16_ONE;
							k_q       <= '0;
							d_q       <= '0;
						end else if (in_data.func != FUNC_LOAD) begin
							if (!started_q) begin
								res_status_q <= STATUS_NOT_STARTED;
							end else if (in_data.func == FUNC_STEP) begin
								r_q      <= '0;
								c_q      <= '0;
								best_q   <= '0;
								peak_r_q <= '0;
								peak_c_q <= '0;
							end
						end
					end
				end
				S_RD_WAIT: begin
					if ((int'(item_q.cell_row) < int'(act_rows)) &&
						(int'(item_q.cell_col) < int'(act_cols))) begin
						res_belief_q <= read_ext[BELIEF_BITS+15 -: 16];
					end
				end
				S_W_UPD: begin
					if (k_q == 4'd7) begin
						weight_q[d_q] <= w_new[16] ? 16'hFFFF : w_new[15:0];
						w_q <= Q16_ONE;
						k_q <= '0;
						d_q <= d_q + 4'd1;
						if (d_q == 4'd8) begin
							r_q      <= '0;
							c_q      <= '0;
							best_q   <= '0;
							peak_r_q <= '0;
							peak_c_q <= '0;
						end
					end else begin
						w_q <= w_new;
						k_q <= k_q + 4'd1;
					end
				end
				S_M_CHK: begin
					m_q <= ALL_BLOCKED;
					k_q <= '0;
				end
				S_M_NB: begin
					if (k_q != 4'd8 && !nb_in) begin
						k_q <= k_q + 4'd1;
					end
				end
				S_M_NBD: begin
					if (!wall_rd) begin
						m_q[k_q[2:0]] <= 1'b0;
					end
					k_q <= k_q + 4'd1;
				end
				S_P_CHK: begin
					m_q    <= mask_rd;
					k_q    <= '0;
					sum_q  <= '0;
					pend_q <= 1'b0;
				end
				S_P_NB: begin
					if (pend_q) begin
						sum_q  <= sum_q + SW'(quot);
						pend_q <= 1'b0;
					end
					if (k_q != 4'd8 && !(!m_q[k_q[2:0]] && nb_in)) begin
						k_q <= k_q + 4'd1;
					end
				end
				S_P_DIV: begin
					pend_q <= (cnt != 4'd0);
					k_q    <= k_q + 4'd1;
				end
				S_N_INIT: begin
					tmp_q <= best_q;
					sh_q  <= '0;
					r_q   <= '0;
					c_q   <= '0;
					res_status_q <= (best_q == '0) ? STATUS_ALL_ZERO : STATUS_OK;
				end
				S_N_MSB: begin
					if (!msb_done) begin
						tmp_q <= tmp_q << 1;
						sh_q  <= sh_q + SHW'(1);
					end
				end
				S_DONE: begin
					if (!out_valid_q) begin
						out_valid_q    <= 1'b1;
						out_q.belief   <= res_belief_q;
						out_q.peak_row <= 4'(peak_r_q);
						out_q.peak_col <= 4'(peak_c_q);
						out_q.status   <= res_status_q;
					end
				end
				default: begin
				end
			endcase

			// advance to the next active cell
			if ((state_q == S_M_CHK && wall_rd) || state_q == S_M_WR ||
				(state_q == S_P_CHK && mask_rd == ALL_BLOCKED) ||
				state_q == S_P_WR || state_q == S_N_WR) begin
				if (last_col) begin
					c_q <= '0;
					r_q <= r_q + RIW'(1);
				end else begin
					c_q <= c_q + CIW'(1);
				end
			end
		end
	end

	gmlf_ram #(.WIDTH(1), .ADDR_W(AW)) u_wall_ram (
		.clk   (clk),
		.we    (wall_we),
		.waddr (wall_waddr),
		.wdata (wall_wdata),
		.raddr (wall_raddr),
		.rdata (wall_rd)
	);

	gmlf_ram #(.WIDTH(8), .ADDR_W(AW)) u_mask_ram (
		.clk   (clk),
		.we    (mask_we),
		.waddr (mask_waddr),
		.wdata (mask_wdata),
		.raddr (mask_raddr),
		.rdata (mask_rd)
	);

	gmlf_ram #(.WIDTH(BELIEF_BITS), .ADDR_W(AW)) u_belief_ram (
		.clk   (clk),
		.we    (bel_we),
		.waddr (bel_waddr),
		.wdata (bel_wdata),
		.raddr (bel_raddr),
		.rdata (bel_rd)
	);

	gmlf_ram #(.WIDTH(RWW), .ADDR_W(AW)) u_raw_ram (
		.clk   (clk),
		.we    (raw_we),
		.waddr (raw_waddr),
		.wdata (raw_wdata),
		.raddr (raw_raddr),
		.rdata (raw_rd)
	);

	gmlf_mul #(.A_W(MA), .B_W(MB)) u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

`ifndef SYNTHESIS
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result transaction raised outside the done state");

	a_dir_bound: assert property (@(posedge clk) disable iff (!arst_n)
		k_q <= 4'd8)
		else $error("direction counter out of range");

	a_pass_started: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_P_OWN || state_q == S_N_RD) |-> started_q)
		else $error("filter pass running while not started");
`endif

endmodule

// ===== hw/rtl/gmlf_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmlf_ram: single write, single read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gmlf_ram #(
	parameter int WIDTH  = 16,
	parameter int ADDR_W = 8
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [1 << ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hw/rtl/gmlf_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmlf_mul: shared multiplier
// Unsigned multiply with a registered product, time-shared by the sequencer.
// ----------------------------------------------------------------------------
module gmlf_mul #(
	parameter int A_W = 28,
	parameter int B_W = 27
) (
	input  logic                 clk,
	input  logic [A_W-1:0]       a,
	input  logic [B_W-1:0]       b,
	output logic [A_W+B_W-1:0]   p
);

	always_ff @(posedge clk) begin
		p <= a * b;
	end

endmodule

// ===== bench/tb_grid_markov_localization_filter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grid_markov_localization_filter_top: bench for the grid localization filter
// Drives load, start, step and read transactions with random gaps on both
// channels. A behavioural copy of the filter predicts every result, and a
// checker compares each accepted result field by field, in order.
// ----------------------------------------------------------------------------
module tb_grid_markov_localization_filter_top;
	import gmlf_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	in_item_t    in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_item_t   out_data;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_addr = CFG_SENSOR_ERROR;
	logic [15:0] cfg_wdata = '0;

	grid_markov_localization_filter_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	initial begin
		#20ms;
		$display("tb_grid_markov_localization_filter_top: done, errors");
		$finish;
	end

	// filter state copy
	logic [15:0]     f_err;
	logic [4:0]      f_rows, f_cols;
	bit              f_wall [256];
	logic [7:0]      f_mask [256];
	longint unsigned f_bel [256];
	longint unsigned f_raw [256];
	longint unsigned f_w [9];
	bit              f_started;
	int              f_peak;

	out_item_t pending_results [$];
	int        errors = 0;
	int        n_sent = 0, n_steps = 0, n_reads = 0, n_seen = 0;
	bit        quiet = 1'b0;
	int        stall_left = 0;

	function automatic int rows_used();
		return (f_rows < 1) ? 1 : (f_rows > 16) ? 16 : int'(f_rows);
	endfunction

	function automatic int cols_used();
		return (f_cols < 1) ? 1 : (f_cols > 16) ? 16 : int'(f_cols);
	endfunction

	function automatic bit rescale_beliefs();
		longint unsigned best;
		int bi, msb, nr, nc;
		best = 0; bi = 0; msb = 0;
		nr = rows_used(); nc = cols_used();
		for (int i = 0; i < 256; i++) f_bel[i] = 0;
		for (int r = 0; r < nr; r++)
			for (int c = 0; c < nc; c++)
				if (f_raw[r*16+c] > best) begin
					best = f_raw[r*16+c];
					bi = r*16+c;
				end
		f_peak = bi;
		if (best == 0) return 1'b1;
		while (msb < 63 && (best >> (msb + 1)) != 0) msb++;
		for (int r = 0; r < nr; r++)
			for (int c = 0; c < nc; c++)
				if (msb > 15) f_bel[r*16+c] = f_raw[r*16+c] >> (msb - 15);
				else f_bel[r*16+c] = f_raw[r*16+c] << (15 - msb);
		return 1'b0;
	endfunction

	function automatic bit start_beliefs();
		longint unsigned w, q;
		int nr, nc, yr, xc;
		logic [7:0] m;
		nr = rows_used(); nc = cols_used();
		q = 65536 - f_err;
		for (int d = 0; d < 9; d++) begin
			w = 65536;
			for (int k = 0; k < 8; k++)
				w = (w * ((k < d) ? longint'(f_err) : q) + 32768) >> 16;
			f_w[d] = (w > 65535) ? 65535 : w;
		end
		for (int i = 0; i < 256; i++) begin
			f_mask[i] = ALL_BLOCKED;
			f_raw[i] = 0;
		end
		for (int r = 0; r < nr; r++)
			for (int c = 0; c < nc; c++) begin
				if (f_wall[r*16+c]) continue;
				m = ALL_BLOCKED;
				for (int k = 0; k < 8; k++) begin
					yr = r + DIR_DY[k]; xc = c + DIR_DX[k];
					if (yr >= 0 && yr < nr && xc >= 0 && xc < nc && !f_wall[yr*16+xc])
						m[k] = 1'b0;
				end
				f_mask[r*16+c] = m;
				f_raw[r*16+c] = 64'd1 << 15;
			end
		f_started = 1'b1;
		return rescale_beliefs();
	endfunction

	function automatic bit step_beliefs(logic [7:0] sensed);
		longint unsigned sum;
		int nr, nc, yr, xc, n, cnt;
		logic [7:0] m;
		nr = rows_used(); nc = cols_used();
		for (int i = 0; i < 256; i++) f_raw[i] = 0;
		for (int r = 0; r < nr; r++)
			for (int c = 0; c < nc; c++) begin
				m = f_mask[r*16+c];
				if (m == ALL_BLOCKED) continue;
				sum = 0;
				for (int k = 0; k < 8; k++) begin
					yr = r + DIR_DY[k]; xc = c + DIR_DX[k];
					if (m[k]) continue;
					if (yr < 0 || yr >= nr || xc < 0 || xc >= nc) continue;
					n = yr*16 + xc;
					cnt = 8 - $countones(f_mask[n]);
					if (cnt == 0) continue;
					sum += (f_bel[n] << 8) / longint'(cnt);
				end
				f_raw[r*16+c] = sum * f_w[$countones(m ^ sensed)];
			end
		return rescale_beliefs();
	endfunction

	function automatic out_item_t predict_result(in_item_t it);
		out_item_t e;
		e = '0;
		case (it.func)
			FUNC_LOAD: f_wall[it.cell_row*16 + it.cell_col] = it.cell_wall;
			FUNC_START: e.status = start_beliefs() ? STATUS_ALL_ZERO : STATUS_OK;
			FUNC_STEP:
				if (!f_started) e.status = STATUS_NOT_STARTED;
				else e.status = step_beliefs(it.sensed_mask) ? STATUS_ALL_ZERO : STATUS_OK;
			default:
				if (!f_started) e.status = STATUS_NOT_STARTED;
				else if (it.cell_row < rows_used() && it.cell_col < cols_used())
					e.belief = f_bel[it.cell_row*16 + it.cell_col][15:0];
		endcase
		e.peak_row = 4'(f_peak / 16);
		e.peak_col = 4'(f_peak % 16);
		return e;
	endfunction

	// receiver: random back-pressure, or a counted hold-off on request
	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left = stall_left - 1;
		end else begin
			out_ready <= quiet || ($urandom_range(99) >= 28);
		end
	end

	// checker: outputs are stable at the falling edge before the accepting edge
	always @(negedge clk) begin
		out_item_t e;
		if (arst_n && out_valid && out_ready) begin
			n_seen++;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result %h", $time, out_data);
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (out_data.belief !== e.belief) begin
					$display("%0t: belief exp %h got %h", $time, e.belief, out_data.belief);
					errors++;
				end
				if (out_data.peak_row !== e.peak_row) begin
					$display("%0t: peak_row exp %0d got %0d", $time, e.peak_row,
						out_data.peak_row);
					errors++;
				end
				if (out_data.peak_col !== e.peak_col) begin
					$display("%0t: peak_col exp %0d got %0d", $time, e.peak_col,
						out_data.peak_col);
					errors++;
				end
				if (out_data.status !== e.status) begin
					$display("%0t: status exp %0d got %0d", $time, e.status, out_data.status);
					errors++;
				end
			end
		end
	end

	task automatic send_item(in_item_t it);
		bit acc;
		if (!quiet && $urandom_range(99) < 28) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		pending_results.push_back(predict_result(it));
		in_valid <= 1'b1;
		in_data <= it;
		n_sent++;
		if (it.func == FUNC_STEP) n_steps++;
		if (it.func == FUNC_READ) n_reads++;
		do begin
			@(negedge clk);
			acc = in_ready;
			@(posedge clk);
		end while (!acc);
	endtask

	task automatic send_op(func_e f, int r, int c, bit w, logic [7:0] m);
		in_item_t it;
		it.func = f;
		it.cell_row = r[3:0];
		it.cell_col = c[3:0];
		it.cell_wall = w;
		it.sensed_mask = m;
		send_item(it);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_SENSOR_ERROR: f_err = v;
			CFG_GRID_ROWS: begin f_rows = v[4:0]; f_started = 1'b0; end
			default: begin f_cols = v[4:0]; f_started = 1'b0; end
		endcase
		@(posedge clk);
	endtask

	task automatic test_not_started();
		send_op(FUNC_STEP, 0, 0, 1'b0, 8'h00);
		send_op(FUNC_READ, 15, 15, 1'b1, 8'hFF);
	endtask

	task automatic test_map_and_basics();
		// define every cell that any grid used below can reach
		quiet = 1'b1;
		for (int i = 0; i < 256; i++)
			if ((i / 16 < 6 && i % 16 < 6) || i / 16 == 0 || i % 16 == 0)
				send_op(FUNC_LOAD, i / 16, i % 16, 1'b0, 8'($urandom));
		quiet = 1'b0;
		write_reg(CFG_GRID_ROWS, 16'd4);
		write_reg(CFG_GRID_COLS, 16'd5);
		send_op(FUNC_LOAD, 1, 1, 1'b1, 8'h00);
		send_op(FUNC_LOAD, 3, 3, 1'b1, 8'h00);
		send_op(FUNC_LOAD, 3, 4, 1'b1, 8'h00);
		send_op(FUNC_LOAD, 2, 4, 1'b1, 8'h00);
		send_op(FUNC_START, 0, 0, 1'b0, 8'h00);
		send_op(FUNC_STEP, 0, 0, 1'b0, 8'h00);
		send_op(FUNC_STEP, 0, 0, 1'b1, 8'hFF);
		send_op(FUNC_READ, 0, 0, 1'b0, 8'h00);
		send_op(FUNC_READ, 3, 2, 1'b1, 8'hFF);
		send_op(FUNC_READ, 15, 0, 1'b0, 8'h00);
		send_op(FUNC_READ, 0, 15, 1'b0, 8'h00);
		send_op(FUNC_LOAD, 0, 0, 1'b1, 8'h00);
		send_op(FUNC_STEP, 0, 0, 1'b0, 8'h5A);
		send_op(FUNC_READ, 0, 0, 1'b0, 8'h00);
		send_op(FUNC_LOAD, 0, 0, 1'b0, 8'h00);
	endtask

	task automatic test_edge_settings();
		// single cell: isolated, so every step leaves all beliefs at zero
		write_reg(CFG_GRID_ROWS, 16'd0);
		write_reg(CFG_GRID_COLS, 16'd1);
		send_op(FUNC_START, 0, 0, 1'b0, 8'h00);
		send_op(FUNC_STEP, 0, 0, 1'b0, 8'hFF);
		send_op(FUNC_READ, 0, 0, 1'b0, 8'h00);
		write_reg(CFG_SENSOR_ERROR, 16'd0);
		write_reg(CFG_GRID_ROWS, 16'd31);
		write_reg(CFG_GRID_COLS, 16'd1);
		send_op(FUNC_START, 0, 0, 1'b0, 8'h00);
		send_op(FUNC_STEP, 0, 0, 1'b0, 8'hFC);
		write_reg(CFG_SENSOR_ERROR, 16'hFFFF);
		send_op(FUNC_START, 0, 0, 1'b0, 8'h00);
		send_op(FUNC_STEP, 0, 0, 1'b0, 8'h03);
		send_op(FUNC_READ, 15, 0, 1'b0, 8'h00);
	endtask

	task automatic test_clamped_cols();
		write_reg(CFG_SENSOR_ERROR, 16'd3277);
		write_reg(CFG_GRID_ROWS, 16'd1);
		write_reg(CFG_GRID_COLS, 16'd17);
		send_op(FUNC_START, 0, 0, 1'b0, 8'h00);
		send_op(FUNC_STEP, 0, 0, 1'b0, 8'($urandom));
		send_op(FUNC_READ, 0, 15, 1'b0, 8'h00);
	endtask

	task automatic test_random_run();
		int nr, nc, pick;
		int loops;
		loops = 0;
		while (loops < 40) begin
			loops++;
			quiet = (loops >= 15 && loops < 25);
			pick = $urandom_range(99);
			if (pick < 9) begin
				nr = $urandom_range(1, 6);
				nc = $urandom_range(1, 6);
				write_reg(CFG_SENSOR_ERROR, 16'($urandom));
				write_reg(CFG_GRID_ROWS, 16'(nr));
				write_reg(CFG_GRID_COLS, 16'(nc));
				for (int k = 0; k < 3; k++)
					send_op(FUNC_LOAD, $urandom_range(0, nr), $urandom_range(0, nc),
						$urandom_range(99) < 30, 8'($urandom));
				send_op(FUNC_START, $urandom, $urandom, 1'($urandom), 8'($urandom));
			end else if (pick < 50) begin
				send_op(FUNC_STEP, $urandom, $urandom, 1'($urandom), 8'($urandom));
			end else if (pick < 85) begin
				send_op(FUNC_READ, $urandom_range(0, rows_used()), $urandom_range(0, cols_used()),
					1'($urandom), 8'($urandom));
			end else if (pick < 95) begin
				send_op(FUNC_LOAD, $urandom, $urandom, $urandom_range(99) < 30, 8'($urandom));
			end else begin
				send_op(FUNC_START, $urandom, $urandom, 1'($urandom), 8'($urandom));
			end
		end
		quiet = 1'b0;
	endtask

	task automatic test_backpressure();
		write_reg(CFG_GRID_ROWS, 16'd3);
		write_reg(CFG_GRID_COLS, 16'd3);
		send_op(FUNC_START, 0, 0, 1'b0, 8'h00);
		drain();
		stall_left = 400;
		for (int k = 0; k < 6; k++)
			send_op(FUNC_READ, $urandom_range(0, 3), $urandom_range(0, 3), 1'b0, 8'($urandom));
		send_op(FUNC_STEP, 0, 0, 1'b0, 8'($urandom));
		drain();
	endtask

	initial begin
		int waited;
		f_err = 16'd3277; f_rows = 5'd16; f_cols = 5'd16;
		f_started = 1'b0; f_peak = 0;
		for (int i = 0; i < 256; i++) begin
			f_wall[i] = 1'b0; f_mask[i] = '0; f_bel[i] = 0; f_raw[i] = 0;
		end
		for (int d = 0; d < 9; d++) f_w[d] = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_not_started();
		test_map_and_basics();
		test_edge_settings();
		test_clamped_cols();
		test_backpressure();
		test_random_run();
		drain();
		waited = 0;
		while (waited < 200) begin
			@(posedge clk);
			waited++;
		end
		$display("covered %0d transactions (%0d steps, %0d reads), %0d results checked",
			n_sent, n_steps, n_reads, n_seen);
		$display("register extremes, clamped grid sizes, stalls and idle gaps exercised");
		if (errors == 0 && pending_results.size() == 0)
			$display("tb_grid_markov_localization_filter_top: done, clean");
		else
			$display("tb_grid_markov_localization_filter_top: done, errors");
		$finish;
	end

endmodule
